/* hdl/dgadv_pkg.sv */
// Shared types and constants for the DG advection element update block.
package dgadv_pkg;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 16;
    localparam int INDEX_W  = 10;
    localparam int DIFF_W   = 27;
    localparam int PROD_W   = 44;
    localparam int FRAC_W   = 16;
    localparam int JOB_SLOTS = 3;

    localparam logic [COEF_W-1:0] COEF_RESET = 16'd10430;

    localparam logic signed [SAMPLE_W:0] SAMPLE_MAX = 25'sd8388607;
    localparam logic signed [SAMPLE_W:0] SAMPLE_MIN = -25'sd8388608;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // One pending element update: upwind neighbor value and the element's two nodes.
    typedef struct packed {
        t_sample              lft;
        t_sample              u0;
        t_sample              u1;
        logic [INDEX_W-1:0]   idx;
        logic                 done;
        logic                 short_sweep;
    } t_job;

endpackage

/* hdl/dg_advection_element_update.sv */
// One explicit upwind DG step for linear advection over a streamed periodic mesh.
//
// Elements enter on the input channel (i_valid / o_stall), one per request, in
// mesh order; i_final_element marks the last one. Updated elements leave on the
// output channel (o_valid / i_stall). The update of element k is issued when
// element k+1 is accepted; the final element issues three updates: its
// predecessor, itself, and element 0 (flagged with sweep_done). A sweep of fewer
// than three elements yields a single result with short_sweep set.
// An accepted request loads a small job queue; the queue head goes through one
// pair of multipliers into a product register and then through rounding and
// saturation into the output register, which drives o_valid. Throughput is one
// element per cycle while i_stall is low; the final element of a sweep holds the
// input while its three updates drain through the single multiplier pair.
// i_stall backs up the pipeline and raises o_stall once the queue cannot take a
// new job. The coefficient is written through i_cfg_valid / i_cfg_data (always
// ready) while the block is idle (a user rule, not enforced). Synchronous reset
// restores the default coefficient, empties the pipeline and starts a new sweep.
module dg_advection_element_update #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  dgadv_pkg::t_sample             i_node_left,
    input  dgadv_pkg::t_sample             i_node_right,
    input  logic                           i_final_element,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [dgadv_pkg::INDEX_W-1:0]  o_element_index,
    output dgadv_pkg::t_sample             o_new_left,
    output dgadv_pkg::t_sample             o_new_right,
    output logic                           o_sweep_done,
    output logic                           o_short_sweep,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [dgadv_pkg::COEF_W-1:0]   i_cfg_data
);
    import dgadv_pkg::*;

    localparam int CW = $clog2(MAX_ELEMENTS);
    localparam logic [CW-1:0] LAST_POS = CW'(MAX_ELEMENTS - 1);
    localparam logic [CW-1:0] ONE_POS  = CW'(1);
    localparam logic [CW-1:0] TWO_POS  = CW'(2);

    function automatic logic [INDEX_W-1:0] to_index(input logic [CW-1:0] pos);
        logic [CW+INDEX_W-1:0] wide;
        wide = {{INDEX_W{1'b0}}, pos};
        return wide[INDEX_W-1:0];
    endfunction

    // Sweep state.
    logic [COEF_W-1:0] r_step_coef;
    logic [CW-1:0]     r_count, n_count;
    t_sample           r_first_left, n_first_left;
    t_sample           r_first_right, n_first_right;
    t_sample           r_held_left, n_held_left;
    t_sample           r_held_right, n_held_right;
    t_sample           r_before_right, n_before_right;

    // Job queue, head at slot 0.
    t_job              r_job [JOB_SLOTS];
    t_job              n_job [JOB_SLOTS];
    logic [1:0]        r_job_cnt, n_job_cnt;

    // Product stage.
    logic                      r_c_valid;
    logic signed [PROD_W-1:0]  r_c_p0, r_c_p1;
    t_sample                   r_c_u0, r_c_u1;
    logic [INDEX_W-1:0]        r_c_idx;
    logic                      r_c_done, r_c_short;

    // Output register.
    logic                      r_out_valid;
    logic [INDEX_W-1:0]        r_out_idx;
    t_sample                   r_out_left, r_out_right;
    logic                      r_out_done, r_out_short;

    logic accept, out_free, out_load, c_load;
    logic fin;

    assign out_free = !r_out_valid || !i_stall;
    assign out_load = r_c_valid && out_free;
    assign c_load   = (r_job_cnt != 2'd0) && (!r_c_valid || out_free);
    assign o_stall  = !((r_job_cnt == 2'd0) || ((r_job_cnt == 2'd1) && c_load));
    assign accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // Sweep bookkeeping and the set of updates one element releases.
    always_comb begin
        t_job prev_job;
        n_count        = r_count;
        n_first_left   = r_first_left;
        n_first_right  = r_first_right;
        n_held_left    = r_held_left;
        n_held_right   = r_held_right;
        n_before_right = r_before_right;
        n_job          = r_job;
        n_job_cnt      = r_job_cnt;

        fin = i_final_element || (r_count == LAST_POS);

        prev_job.lft         = r_before_right;
        prev_job.u0          = r_held_left;
        prev_job.u1          = r_held_right;
        prev_job.idx         = to_index(r_count - ONE_POS);
        prev_job.done        = 1'b0;
        prev_job.short_sweep = 1'b0;

        if (c_load) begin
            n_job[0]  = r_job[1];
            n_job[1]  = r_job[2];
            n_job_cnt = r_job_cnt - 2'd1;
        end

        if (accept) begin
            if (r_count == '0) begin
                n_first_left  = i_node_left;
                n_first_right = i_node_right;
            end else if (r_count == ONE_POS) begin
                n_before_right = r_first_right;
                n_held_left    = i_node_left;
                n_held_right   = i_node_right;
            end else begin
                n_before_right = r_held_right;
                n_held_left    = i_node_left;
                n_held_right   = i_node_right;
            end

            if (!fin) begin
                n_count   = r_count + ONE_POS;
                n_job[0]  = prev_job;
                n_job_cnt = (r_count >= TWO_POS) ? 2'd1 : 2'd0;
            end else if (r_count < TWO_POS) begin
                // Too few elements for a periodic sweep: report and restart.
                n_count              = '0;
                n_job[0].lft         = '0;
                n_job[0].u0          = '0;
                n_job[0].u1          = '0;
                n_job[0].idx         = '0;
                n_job[0].done        = 1'b1;
                n_job[0].short_sweep = 1'b1;
                n_job_cnt            = 2'd1;
            end else begin
                // Predecessor, this element, then element 0 closing the ring.
                n_count              = '0;
                n_job[0]             = prev_job;
                n_job[1].lft         = r_held_right;
                n_job[1].u0          = i_node_left;
                n_job[1].u1          = i_node_right;
                n_job[1].idx         = to_index(r_count);
                n_job[1].done        = 1'b0;
                n_job[1].short_sweep = 1'b0;
                n_job[2].lft         = i_node_right;
                n_job[2].u0          = r_first_left;
                n_job[2].u1          = r_first_right;
                n_job[2].idx         = '0;
                n_job[2].done        = 1'b1;
                n_job[2].short_sweep = 1'b0;
                n_job_cnt            = 2'd3;
            end
        end
    end

    // Flux differences and their scaling by the step coefficient.
    logic signed [DIFF_W-1:0] d0, d1, lft_x, u0_x, u1_x;
    logic signed [PROD_W-1:0] p0, p1;
    logic signed [COEF_W:0]   coef_s;

    always_comb begin
        lft_x  = DIFF_W'(r_job[0].lft);
        u0_x   = DIFF_W'(r_job[0].u0);
        u1_x   = DIFF_W'(r_job[0].u1);
        d0     = (lft_x <<< 2) - (u0_x <<< 1) - u0_x - u1_x;
        d1     = (u0_x <<< 1) + u0_x - (lft_x <<< 1) - u1_x;
        coef_s = $signed({1'b0, r_step_coef});
        p0     = PROD_W'(coef_s) * PROD_W'(d0);
        p1     = PROD_W'(coef_s) * PROD_W'(d1);
    end

    // Round to nearest (ties up), add to the old node and saturate; a short sweep gives zero nodes.
    localparam int ROUND_W = PROD_W - FRAC_W;
    localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(1) <<< (FRAC_W - 1);

    logic signed [PROD_W-1:0]    q0, q1;
    logic signed [SAMPLE_W:0]    s0_lo, s1_lo;
    logic signed [ROUND_W:0]     sum0, sum1;
    t_sample                     new0, new1;

    function automatic t_sample saturate(input logic signed [ROUND_W:0] v);
        if (v > (ROUND_W+1)'(SAMPLE_MAX)) begin
            return SAMPLE_MAX[SAMPLE_W-1:0];
        end else if (v < (ROUND_W+1)'(SAMPLE_MIN)) begin
            return SAMPLE_MIN[SAMPLE_W-1:0];
        end
        return v[SAMPLE_W-1:0];
    endfunction

    always_comb begin
        q0    = r_c_p0 + HALF_LSB;
        q1    = r_c_p1 + HALF_LSB;
        s0_lo = (SAMPLE_W+1)'(r_c_u0);
        s1_lo = (SAMPLE_W+1)'(r_c_u1);
        sum0  = (ROUND_W+1)'($signed(q0[PROD_W-1:FRAC_W])) + (ROUND_W+1)'(s0_lo);
        sum1  = (ROUND_W+1)'($signed(q1[PROD_W-1:FRAC_W])) + (ROUND_W+1)'(s1_lo);
        new0  = r_c_short ? '0 : saturate(sum0);
        new1  = r_c_short ? '0 : saturate(sum1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_coef <= COEF_RESET;
            r_count     <= '0;
            r_job_cnt   <= 2'd0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step_coef <= i_cfg_data;
            end
            r_count   <= n_count;
            r_job_cnt <= n_job_cnt;
            if (c_load) begin
                r_c_valid <= 1'b1;
            end else if (out_load) begin
                r_c_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_left   <= n_first_left;
        r_first_right  <= n_first_right;
        r_held_left    <= n_held_left;
        r_held_right   <= n_held_right;
        r_before_right <= n_before_right;
        r_job          <= n_job;
        if (c_load) begin
            r_c_p0    <= p0;
            r_c_p1    <= p1;
            r_c_u0    <= r_job[0].u0;
            r_c_u1    <= r_job[0].u1;
            r_c_idx   <= r_job[0].idx;
            r_c_done  <= r_job[0].done;
            r_c_short <= r_job[0].short_sweep;
        end
        if (out_load) begin
            r_out_idx   <= r_c_idx;
            r_out_left  <= new0;
            r_out_right <= new1;
            r_out_done  <= r_c_done;
            r_out_short <= r_c_short;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_element_index = r_out_idx;
    assign o_new_left      = r_out_left;
    assign o_new_right     = r_out_right;
    assign o_sweep_done    = r_out_done;
    assign o_short_sweep   = r_out_short;

endmodule
